/* design/i2cm_pkg.sv */
// Shared types, codes and helpers for the byte-level I2C master.
`default_nettype none
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_SP_A  = 4'd3,
    PH_SP_B  = 4'd4,
    PH_SP_C  = 4'd5,
    PH_AK_A  = 4'd6,
    PH_AK_B  = 4'd7,
    PH_AK_C  = 4'd8,
    PH_WR_LO = 4'd9,
    PH_WR_HI = 4'd10,
    PH_WR_AS = 4'd11,
    PH_WR_AH = 4'd12,
    PH_RD_HI = 4'd13,
    PH_RD_LO = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_t;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_SHORT_DELAY = 1'b1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] tick_count;
    logic [7:0] shift_reg;
    logic       clock_out;
    logic       data_low;
    logic       ack_reg;
    logic [7:0] rx_last;
  } state_t;

  // A zero delay counts as one tick.
  function automatic logic [7:0] eff_len(input logic [7:0] v);
    eff_len = (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage
`default_nettype wire

/* design/i2c_bit_level_master_top.sv */
// Byte-level I2C master driven by one timing tick per input transfer.
//
// Each input transfer is one tick: cmd (taken only while idle), tx_byte for a
// write and the sampled SDA level. Each accepted tick yields exactly one
// output transfer carrying the line levels after that tick (scl_level,
// sda_drive_low), busy_res, a done_res pulse on the finishing tick, the last
// read byte and the last write acknowledge.
// A tick accepted at one edge shows its result on the output from the next
// cycle. Throughput is one tick per cycle while in_stall is low; the sequencer
// state and the output register both update at the accepting edge.
// in_stall rises only while a result sits in the output register and the
// receiver stalls it; the result then holds and no tick is taken.
// Configuration writes (half period, short delay) land on the edge cfg_wr_en
// is high and are meant for idle periods only.
// Reset (rst, synchronous) returns the sequencer to idle with SCL high, SDA
// released, counters and captured bytes cleared, and the delay registers at
// 5 and 2 ticks.
`default_nettype none
module i2c_bit_level_master_top
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] tx_byte,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            scl_level,
  output logic            sda_drive_low,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_bit,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  state_t     st;
  state_t     st_next;
  logic       done_next;
  logic [7:0] half_period;
  logic [7:0] short_delay;
  logic       take;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  i2cm_step u_step (
    .cur         (st),
    .half_period (half_period),
    .short_delay (short_delay),
    .cmd         (cmd),
    .tx_byte     (tx_byte),
    .sda_in      (sda_in),
    .nxt         (st_next),
    .done        (done_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= 8'd5;
      short_delay <= 8'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period <= cfg_data;
        CFG_SHORT_DELAY: short_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.bit_count  <= 4'd0;
      st.tick_count <= 8'd0;
      st.shift_reg  <= 8'd0;
      st.clock_out  <= 1'b1;
      st.data_low   <= 1'b0;
      st.ack_reg    <= 1'b0;
      st.rx_last    <= 8'd0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk) begin
    if (take) begin
      scl_level     <= st_next.clock_out;
      sda_drive_low <= st_next.data_low;
      busy_res      <= (st_next.phase != PH_IDLE);
      done_res      <= done_next;
      rx_byte       <= st_next.rx_last;
      ack_bit       <= st_next.ack_reg;
    end
  end

endmodule
`default_nettype wire

/* design/i2cm_step.sv */
// Next-state logic for one tick of the I2C master phase sequencer.
`default_nettype none
module i2cm_step
  import i2cm_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] half_period,
  input  logic [7:0] short_delay,
  input  logic [2:0] cmd,
  input  logic [7:0] tx_byte,
  input  logic       sda_in,
  output state_t     nxt,
  output logic       done
);

  logic [7:0] len;
  logic [7:0] tick_inc;
  logic [3:0] bit_inc;
  logic [7:0] shift_up;

  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    tick_inc = cur.tick_count + 8'd1;
    bit_inc  = cur.bit_count + 4'd1;
    shift_up = {cur.shift_reg[6:0], 1'b0};
    if (cur.phase == PH_WR_AS || cur.phase == PH_SP_C) begin
      len = eff_len(short_delay);
    end else begin
      len = eff_len(half_period);
    end

    if (cur.phase == PH_IDLE) begin
      nxt.tick_count = 8'd0;
      nxt.bit_count  = 4'd0;
      case (cmd_t'(cmd))
        CMD_START: begin
          nxt.phase = PH_ST_A; nxt.clock_out = 1'b1; nxt.data_low = 1'b0;
        end
        CMD_STOP: begin
          nxt.phase = PH_SP_A; nxt.clock_out = 1'b1; nxt.data_low = 1'b1;
        end
        CMD_WRITE: begin
          nxt.phase = PH_WR_LO; nxt.clock_out = 1'b0;
          nxt.shift_reg = tx_byte; nxt.data_low = ~tx_byte[7];
        end
        CMD_READ: begin
          nxt.phase = PH_RD_HI; nxt.clock_out = 1'b1;
          nxt.data_low = 1'b0; nxt.shift_reg = 8'd0;
        end
        CMD_ACK: begin
          nxt.phase = PH_AK_A; nxt.clock_out = 1'b0; nxt.data_low = 1'b1;
        end
        CMD_NACK: begin
          nxt.phase = PH_AK_A; nxt.clock_out = 1'b0; nxt.data_low = 1'b0;
        end
        default: ;
      endcase
    end else begin
      nxt.tick_count = tick_inc;
      if (tick_inc >= len) begin
        nxt.tick_count = 8'd0;
        case (cur.phase)
          PH_ST_A: begin nxt.data_low = 1'b1; nxt.phase = PH_ST_B; end
          PH_ST_B: begin nxt.clock_out = 1'b0; nxt.phase = PH_IDLE; done = 1'b1; end
          PH_SP_A: begin nxt.data_low = 1'b0; nxt.phase = PH_SP_B; end
          PH_SP_B: nxt.phase = PH_SP_C;
          PH_SP_C: begin nxt.phase = PH_IDLE; done = 1'b1; end
          PH_AK_A: begin nxt.clock_out = 1'b1; nxt.phase = PH_AK_B; end
          PH_AK_B: begin nxt.clock_out = 1'b0; nxt.phase = PH_AK_C; end
          PH_AK_C: begin nxt.data_low = 1'b0; nxt.phase = PH_IDLE; done = 1'b1; end
          PH_WR_LO: begin nxt.clock_out = 1'b1; nxt.phase = PH_WR_HI; end
          PH_WR_HI: begin
            nxt.clock_out = 1'b0;
            nxt.shift_reg = shift_up;
            nxt.bit_count = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              nxt.data_low = 1'b0;
              nxt.phase    = PH_WR_AS;
            end else begin
              nxt.data_low = ~shift_up[7];
              nxt.phase    = PH_WR_LO;
            end
          end
          PH_WR_AS: begin nxt.clock_out = 1'b1; nxt.phase = PH_WR_AH; end
          PH_WR_AH: begin
            nxt.ack_reg   = sda_in;
            nxt.clock_out = 1'b0;
            nxt.phase     = PH_IDLE;
            done          = 1'b1;
          end
          PH_RD_HI: begin
            nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
            nxt.clock_out = 1'b0;
            nxt.phase     = PH_RD_LO;
          end
          PH_RD_LO: begin
            nxt.bit_count = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              nxt.rx_last = cur.shift_reg;
              nxt.phase   = PH_IDLE;
              done        = 1'b1;
            end else begin
              nxt.clock_out = 1'b1;
              nxt.phase     = PH_RD_HI;
            end
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* verif/tb_i2c_bit_level_master_top.sv */
// Self-checking testbench for the byte-level I2C master: directed and random bus traffic.
`timescale 1ns / 1ps
module tb_i2c_bit_level_master_top;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int ITEM_TARGET  = 1950;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_CAP   = 50;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } line_levels_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] cmd = 3'd0;
  logic [7:0] tx_byte = 8'd0;
  logic       sda_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_bit;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  // Predicted bus state and timing registers
  phase_t     bus_phase = PH_IDLE;
  logic [3:0] bit_cnt = 4'd0;
  logic [7:0] tick_cnt = 8'd0;
  logic [7:0] shift_q = 8'd0;
  logic [7:0] rx_last = 8'd0;
  logic       scl_q = 1'b1;
  logic       sda_low_q = 1'b0;
  logic       ack_q = 1'b0;
  logic [7:0] half_ticks = 8'd5;
  logic [7:0] short_ticks = 8'd2;

  line_levels_t line_levels_q[$];
  line_levels_t got_lv;
  line_levels_t want_lv;
  int  err_count = 0;
  int  sent_items = 0;
  int  stall_left = 0;
  bit  in_gaps_on = 1'b1;
  bit  stall_on = 1'b1;

  i2c_bit_level_master_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .tx_byte       (tx_byte),
    .sda_in        (sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_level     (scl_level),
    .sda_drive_low (sda_drive_low),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .rx_byte       (rx_byte),
    .ack_bit       (ack_bit),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 8'($urandom_range(1, 6));
    if (r == 8) return 8'($urandom_range(7, 20));
    return 8'd0;
  endfunction

  // Advance the bus sequencer by one tick and return the line levels after it.
  task automatic predict_bus_tick(input logic [2:0] c, input logic [7:0] tx,
                                  input logic sda, output line_levels_t lv);
    logic [7:0] len;
    logic       fin;
    fin = 1'b0;
    if (bus_phase == PH_IDLE) begin
      tick_cnt = 8'd0;
      bit_cnt = 4'd0;
      case (c)
        CMD_START: begin bus_phase = PH_ST_A; scl_q = 1'b1; sda_low_q = 1'b0; end
        CMD_STOP:  begin bus_phase = PH_SP_A; scl_q = 1'b1; sda_low_q = 1'b1; end
        CMD_WRITE: begin
          bus_phase = PH_WR_LO;
          scl_q = 1'b0;
          shift_q = tx;
          sda_low_q = ~tx[7];
        end
        CMD_READ: begin
          bus_phase = PH_RD_HI;
          scl_q = 1'b1;
          sda_low_q = 1'b0;
          shift_q = 8'd0;
        end
        CMD_ACK:  begin bus_phase = PH_AK_A; scl_q = 1'b0; sda_low_q = 1'b1; end
        CMD_NACK: begin bus_phase = PH_AK_A; scl_q = 1'b0; sda_low_q = 1'b0; end
        default: ;
      endcase
    end else begin
      len = (bus_phase == PH_WR_AS || bus_phase == PH_SP_C) ? short_ticks : half_ticks;
      if (len == 8'd0) len = 8'd1;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= len) begin
        tick_cnt = 8'd0;
        case (bus_phase)
          PH_ST_A:  begin sda_low_q = 1'b1; bus_phase = PH_ST_B; end
          PH_ST_B:  begin scl_q = 1'b0; bus_phase = PH_IDLE; fin = 1'b1; end
          PH_SP_A:  begin sda_low_q = 1'b0; bus_phase = PH_SP_B; end
          PH_SP_B:  bus_phase = PH_SP_C;
          PH_SP_C:  begin bus_phase = PH_IDLE; fin = 1'b1; end
          PH_AK_A:  begin scl_q = 1'b1; bus_phase = PH_AK_B; end
          PH_AK_B:  begin scl_q = 1'b0; bus_phase = PH_AK_C; end
          PH_AK_C:  begin sda_low_q = 1'b0; bus_phase = PH_IDLE; fin = 1'b1; end
          PH_WR_LO: begin scl_q = 1'b1; bus_phase = PH_WR_HI; end
          PH_WR_HI: begin
            scl_q = 1'b0;
            shift_q = {shift_q[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              // release SDA for the slave to acknowledge
              sda_low_q = 1'b0;
              bus_phase = PH_WR_AS;
            end else begin
              sda_low_q = ~shift_q[7];
              bus_phase = PH_WR_LO;
            end
          end
          PH_WR_AS: begin scl_q = 1'b1; bus_phase = PH_WR_AH; end
          PH_WR_AH: begin
            ack_q = sda;
            scl_q = 1'b0;
            bus_phase = PH_IDLE;
            fin = 1'b1;
          end
          PH_RD_HI: begin
            shift_q = {shift_q[6:0], sda};
            scl_q = 1'b0;
            bus_phase = PH_RD_LO;
          end
          PH_RD_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              rx_last = shift_q;
              bus_phase = PH_IDLE;
              fin = 1'b1;
            end else begin
              scl_q = 1'b1;
              bus_phase = PH_RD_HI;
            end
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
    end
    lv.scl = scl_q;
    lv.sda_low = sda_low_q;
    lv.busy = (bus_phase != PH_IDLE);
    lv.done = fin;
    lv.rx = rx_last;
    lv.ack = ack_q;
  endtask

  // Entered and left just after a falling edge.
  task automatic send_tick(input logic [2:0] c, input logic [7:0] tx, input logic sda);
    int gap;
    line_levels_t lv;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    tx_byte <= tx;
    sda_in <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    predict_bus_tick(c, tx, sda, lv);
    line_levels_q.push_back(lv);
    @(negedge clk);
  endtask

  // Issue one command and keep ticking until it completes. line_bits gives the
  // slave's read data, or the acknowledge level in bit 0 for a write.
  task automatic run_command(input logic [2:0] c, input logic [7:0] tx,
                             input logic [7:0] line_bits, input bit noisy);
    logic sda;
    send_tick(c, tx, line_bits[0]);
    while (bus_phase != PH_IDLE) begin
      if (noisy) sda = 1'($urandom_range(0, 1));
      else if (c == CMD_READ) sda = line_bits[3'd7 - bit_cnt[2:0]];
      else sda = line_bits[0];
      // commands offered while busy must be dropped
      send_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), sda);
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick($urandom_range(0, 1) ? CMD_NONE : 3'd7, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic set_timing(input logic [7:0] half, input logic [7:0] short_d);
    in_valid <= 1'b0;
    while (line_levels_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_data <= half;
    @(negedge clk);
    cfg_index <= CFG_SHORT_DELAY;
    cfg_data <= short_d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    half_ticks = half;
    short_ticks = short_d;
  endtask

  task automatic test_idle_after_reset();
    send_tick(CMD_NONE, 8'h00, 1'b0);
    send_tick(3'd7, 8'hFF, 1'b1);
    send_tick(CMD_NONE, 8'hFF, 1'b1);
    send_tick(3'd7, 8'h00, 1'b0);
  endtask

  task automatic test_bus_sequences();
    run_command(CMD_START, 8'h00, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h00, 8'h01, 1'b0);
    run_command(CMD_WRITE, 8'h5A, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 8'hA5, 1'b0);
    run_command(CMD_ACK, 8'h00, 8'h00, 1'b0);
    run_command(CMD_READ, 8'hFF, 8'h00, 1'b0);
    run_command(CMD_ACK, 8'h00, 8'hFF, 1'b0);
    run_command(CMD_READ, 8'h00, 8'hFF, 1'b0);
    run_command(CMD_NACK, 8'h00, 8'h00, 1'b0);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0);
    // stop and read on a released bus
    run_command(CMD_STOP, 8'hFF, 8'hFF, 1'b0);
    run_command(CMD_READ, 8'h00, 8'h3C, 1'b1);
    idle_ticks(3);
  endtask

  task automatic test_timing_extremes();
    set_timing(8'd1, 8'd1);
    run_command(CMD_START, 8'h00, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h81, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 8'h7E, 1'b0);
    run_command(CMD_ACK, 8'h00, 8'h00, 1'b0);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0);
    // zero delays count as one tick
    set_timing(8'd0, 8'd0);
    run_command(CMD_START, 8'h00, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hC3, 8'h01, 1'b0);
    run_command(CMD_READ, 8'h00, 8'h96, 1'b0);
    run_command(CMD_NACK, 8'h00, 8'h00, 1'b0);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0);
    // hold both sides busy through the long phases
    in_gaps_on = 1'b0;
    stall_on = 1'b0;
    set_timing(8'd255, 8'd255);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0);
    in_gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int nbytes;
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        in_gaps_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        set_timing(pick_period(), pick_period());
      end
      if ($urandom_range(0, 9) < 8) begin
        run_command(CMD_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        nbytes = $urandom_range(1, 3);
        for (int i = 0; i < nbytes; i++) begin
          if ($urandom_range(0, 1)) begin
            run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'b0);
          end else begin
            run_command(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 7) == 0);
            run_command((i == nbytes - 1) ? CMD_NACK : CMD_ACK, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'b1);
          end
          idle_ticks($urandom_range(0, 2));
        end
        run_command(CMD_STOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // broken sequences: any command in any order with a noisy data line
        repeat ($urandom_range(1, 4))
          run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b1);
      end
      idle_ticks($urandom_range(0, 3));
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_lv = {scl_level, sda_drive_low, busy_res, done_res, rx_byte, ack_bit};
      if (line_levels_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_CAP)
          $display("%0t: unexpected result transfer scl=%b sda_low=%b busy=%b done=%b rx=%h ack=%b",
                   $time, got_lv.scl, got_lv.sda_low, got_lv.busy, got_lv.done, got_lv.rx,
                   got_lv.ack);
      end else begin
        want_lv = line_levels_q.pop_front();
        if (got_lv !== want_lv) begin
          err_count++;
          if (err_count <= REPORT_CAP)
            $display("%0t: mismatch expected scl=%b sda_low=%b busy=%b done=%b rx=%h ack=%b, got scl=%b sda_low=%b busy=%b done=%b rx=%h ack=%b",
                     $time, want_lv.scl, want_lv.sda_low, want_lv.busy, want_lv.done,
                     want_lv.rx, want_lv.ack, got_lv.scl, got_lv.sda_low, got_lv.busy,
                     got_lv.done, got_lv.rx, got_lv.ack);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[i2c_bit_level_master_top] ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_after_reset();
    test_bus_sequences();
    test_timing_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (line_levels_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0)
      $display("[i2c_bit_level_master_top] OK");
    else
      $display("[i2c_bit_level_master_top] ERROR");
    $finish;
  end

endmodule
